>>> rtl/core/dsc_pkg.sv
// Shared types, sizes and helpers for the distinct subsequence counter.
`default_nettype none

package dsc_pkg;

    // Pattern store depth and count row width.
    localparam int MAX_PATTERN = 64;
    localparam int COUNT_WIDTH = 32;

    // Field widths of the stream beats.
    localparam int SYM_W  = 8;
    localparam int MODE_W = 2;
    localparam int OUT_W  = 32;
    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int EXT_W  = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;

    // Item kinds carried in the input tuser.
    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_SOURCE = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic src;      // accepted source symbol
        logic rst_cnt;  // accepted append or clear: counts go to zero
        logic clr;      // accepted clear: pattern emptied
        logic wr_any;   // accepted append that stores a symbol
    } t_cell_ctrl;

    // Clip a count to the output field, saturating when it does not fit.
    function automatic logic [OUT_W-1:0] clip_count(input logic [COUNT_WIDTH-1:0] c);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(c);
        if (ext > EXT_W'({OUT_W{1'b1}})) begin
            return {OUT_W{1'b1}};
        end
        return OUT_W'(ext);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/dsc_cell.sv
// One pattern position: stored symbol, count and saturating update from the left neighbor.
`default_nettype none

module dsc_cell (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire dsc_pkg::t_cell_ctrl                 i_ctrl,
    input  wire logic                                i_wr_sel,    // this cell takes the append
    input  wire logic [dsc_pkg::SYM_W-1:0]           i_symbol,
    input  wire logic [dsc_pkg::COUNT_WIDTH-1:0]     i_left_count,
    output logic      [dsc_pkg::COUNT_WIDTH-1:0]     o_count,
    output logic      [dsc_pkg::COUNT_WIDTH-1:0]     o_next_count,
    output logic                                     o_next_last,
    output logic                                     o_sat_evt
);

    logic [dsc_pkg::SYM_W-1:0]       r_sym;
    logic                            r_active;
    logic                            n_active;
    logic                            r_last;
    logic [dsc_pkg::COUNT_WIDTH-1:0] r_count;
    logic [dsc_pkg::COUNT_WIDTH:0]   w_sum;
    logic                            w_hit;

    // A source symbol that matches an occupied position adds the neighbor's old count.
    assign w_hit = i_ctrl.src && r_active && (r_sym == i_symbol);
    assign w_sum = {1'b0, r_count} + {1'b0, i_left_count};

    always_comb begin
        o_sat_evt    = w_hit && w_sum[dsc_pkg::COUNT_WIDTH];
        o_next_count = r_count;
        if (i_ctrl.rst_cnt) begin
            o_next_count = '0;
        end else if (w_hit) begin
            if (w_sum[dsc_pkg::COUNT_WIDTH]) begin
                o_next_count = {dsc_pkg::COUNT_WIDTH{1'b1}};
            end else begin
                o_next_count = w_sum[dsc_pkg::COUNT_WIDTH-1:0];
            end
        end
    end

    // Occupancy and last-position marker follow appends and clears.
    always_comb begin
        n_active    = r_active;
        o_next_last = r_last;
        if (i_ctrl.clr) begin
            n_active    = 1'b0;
            o_next_last = 1'b0;
        end else if (i_ctrl.wr_any) begin
            o_next_last = i_wr_sel;
            if (i_wr_sel) begin
                n_active = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_last   <= 1'b0;
            r_count  <= '0;
        end else begin
            r_active <= n_active;
            r_last   <= o_next_last;
            r_count  <= o_next_count;
        end
    end

    // Pattern symbol, written once when this position is appended.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_any && i_wr_sel) begin
            r_sym <= i_symbol;
        end
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

>>> rtl/core/distinct_subsequence_counter.sv
// Each accepted input beat has its result beat registered in the output register.
// Throughput: one item per cycle unless the sink stalls; all cells update in parallel, each with one
// saturating adder fed by its left neighbor, so the cell adder plus result select sets the pace.
// Reset (synchronous, active low) empties the pattern, zeroes the counts and the sticky
// saturation flag, and drops any pending result.
`default_nettype none

module distinct_subsequence_counter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [7:0]                    i_s_axis_tdata,   // [7:0] symbol
    input  wire logic [dsc_pkg::MODE_W-1:0]    i_s_axis_tuser,   // [1:0] mode
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic      [31:0]                   o_m_axis_tdata,   // [31:0] match_count
    output logic      [1:0]                    o_m_axis_tuser    // [0] saturated, [1] pattern_full
);

    localparam int N = dsc_pkg::MAX_PATTERN;
    localparam int CW = dsc_pkg::COUNT_WIDTH;

    logic                      w_accept;
    dsc_pkg::t_mode            w_mode;
    logic                      w_full;
    dsc_pkg::t_cell_ctrl       w_ctrl;
    logic [dsc_pkg::LEN_W-1:0] r_len;
    logic [dsc_pkg::LEN_W-1:0] n_len;
    logic                      r_sat;
    logic                      n_sat;
    logic                      r_out_valid;
    logic [31:0]               r_out_count;
    logic                      r_out_sat;
    logic                      r_out_full;
    logic [CW-1:0]             w_count      [N];
    logic [CW-1:0]             w_next_count [N];
    logic [N-1:0]              w_next_last;
    logic [N-1:0]              w_sat_evt;
    logic [CW-1:0]             w_sel_count;
    logic [CW-1:0]             w_result;

    // Input beat handshake: a pending result only blocks when the sink stalls.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_mode          = dsc_pkg::t_mode'(i_s_axis_tuser);
    assign w_full          = (r_len == dsc_pkg::LEN_W'(N));

    // Decode the item kind into the broadcast cell control.
    always_comb begin
        w_ctrl = '0;
        n_len  = r_len;
        if (w_accept) begin
            unique case (w_mode)
                dsc_pkg::MODE_APPEND: begin
                    w_ctrl.rst_cnt = 1'b1;
                    if (!w_full) begin
                        w_ctrl.wr_any = 1'b1;
                        n_len         = r_len + dsc_pkg::LEN_W'(1);
                    end
                end
                dsc_pkg::MODE_SOURCE: begin
                    w_ctrl.src = 1'b1;
                end
                dsc_pkg::MODE_CLEAR: begin
                    w_ctrl.rst_cnt = 1'b1;
                    w_ctrl.clr     = 1'b1;
                    n_len          = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // The row of cells; position one sees the constant count of the empty prefix.
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic [CW-1:0] w_left;
        if (g == 0) begin : g_first
            assign w_left = CW'(1);
        end else begin : g_rest
            assign w_left = w_count[g-1];
        end

        dsc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_wr_sel     (r_len == dsc_pkg::LEN_W'(g)),
            .i_symbol     (i_s_axis_tdata),
            .i_left_count (w_left),
            .o_count      (w_count[g]),
            .o_next_count (w_next_count[g]),
            .o_next_last  (w_next_last[g]),
            .o_sat_evt    (w_sat_evt[g])
        );
    end

    // Pick the count of the last pattern position after this item.
    always_comb begin
        w_sel_count = '0;
        for (int k = 0; k < N; k++) begin
            w_sel_count = w_sel_count | (w_next_last[k] ? w_next_count[k] : '0);
        end
        w_result = (n_len == '0) ? CW'(1) : w_sel_count;
    end

    assign n_sat = r_sat || (|w_sat_evt);

    // Pattern length and sticky saturation flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_sat <= 1'b0;
        end else begin
            r_len <= n_len;
            r_sat <= n_sat;
        end
    end

    // Output register holding one result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_count <= dsc_pkg::clip_count(w_result);
            r_out_sat   <= n_sat;
            r_out_full  <= (w_mode == dsc_pkg::MODE_APPEND) && w_full;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_count;
    assign o_m_axis_tuser  = {r_out_full, r_out_sat};

endmodule

`default_nettype wire
